### sv/greedy_window_point_sampler_unit_assert.svh
`ifndef GREEDY_WINDOW_POINT_SAMPLER_UNIT_ASSERT_SVH
`define GREEDY_WINDOW_POINT_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define GWPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define GWPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gwps_pkg.sv
`default_nettype none

package gwps_pkg;

  // register and field widths
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 11;
  localparam int KERNEL_W     = 6;
  localparam int PIX_W        = 8;
  localparam int POS_OUT_W    = 10;

  // kernel side cap, odd; radius is half of it
  localparam int MAX_KERNEL = 63;
  localparam int RADIUS_W   = KERNEL_W - 1;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = RADIUS_W'(((MAX_KERNEL - 1) | 1) / 2);

  // reset values of the registers
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [KERNEL_W-1:0]     KERNEL_RST = 6'd15;
  localparam logic [PIX_W-1:0]        FG_RST     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_SIZE  = 2'd2,
    REG_FOREGROUND   = 2'd3
  } gwps_reg_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;      // move the ring by one cell
    logic sof_clear;  // frame start: drop old marks before the window write
    logic clear_all;  // frame overrun: drop every mark
    logic wr_en;      // a new center writes its window
    logic ahead_en;   // window has a part at or ahead of the head
  } gwps_ctl_t;

endpackage

`default_nettype wire

### sv/gwps_if.sv
`default_nettype none

interface gwps_pix_if;
  import gwps_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             start_of_frame;

  modport source (output valid, pixel_value, start_of_frame, input ready);
  modport sink (input valid, pixel_value, start_of_frame, output ready);
endinterface

interface gwps_ctr_if;
  import gwps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] center_col;
  logic [POS_OUT_W-1:0] center_row;

  modport source (output valid, center_col, center_row, input ready);
  modport sink (input valid, center_col, center_row, output ready);
endinterface

`default_nettype wire

### sv/gwps_cell.sv
`default_nettype none

module gwps_cell #(
  parameter int IDX = 0,
  parameter int LW  = 11,
  parameter int RW  = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  gwps_pkg::gwps_ctl_t ctl,
  input  logic [LW-1:0]       len,
  input  logic [LW-1:0]       ahead_hi,
  input  logic [LW-1:0]       behind_lo,
  input  logic [LW-1:0]       behind_hi,
  input  logic [RW-1:0]       wr_end,
  input  logic                right_valid,
  input  logic [RW-1:0]       right_end,
  input  logic                wrap_valid,
  input  logic [RW-1:0]       wrap_end,
  output logic                cur_valid,
  output logic [RW-1:0]       cur_end,
  output logic                post_valid,
  output logic [RW-1:0]       post_end
);
  import gwps_pkg::*;

  localparam logic [LW-1:0] MY_IDX = LW'(IDX);

  logic          valid;
  logic [RW-1:0] end_row;
  logic          valid_next;
  logic [RW-1:0] end_row_next;
  logic          in_win;
  logic          takes;
  logic          from_wrap;

  // window hit: ahead part counts from the head, behind part sits at the ring tail
  assign in_win = ctl.wr_en &&
                  ((ctl.ahead_en && (MY_IDX <= ahead_hi)) ||
                   ((MY_IDX >= behind_lo) && (MY_IDX <= behind_hi)));

  assign post_valid = in_win | (valid & ~ctl.sof_clear);
  assign post_end   = in_win ? wr_end : end_row;

  assign takes     = ctl.shift && (MY_IDX < len);
  assign from_wrap = (MY_IDX == (len - LW'(1)));

  always_comb begin
    if (ctl.clear_all) begin
      valid_next   = 1'b0;
      end_row_next = post_end;
    end else if (takes) begin
      valid_next   = from_wrap ? wrap_valid : right_valid;
      end_row_next = from_wrap ? wrap_end : right_end;
    end else begin
      valid_next   = post_valid;
      end_row_next = post_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    end_row <= end_row_next;
  end

  assign cur_valid = valid;
  assign cur_end   = end_row;

endmodule

`default_nettype wire

### sv/gwps_outq.sv
`default_nettype none

`include "greedy_window_point_sampler_unit_assert.svh"

module gwps_outq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [gwps_pkg::POS_OUT_W-1:0] push_col,
  input  logic [gwps_pkg::POS_OUT_W-1:0] push_row,
  output logic                           space,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gwps_pkg::POS_OUT_W-1:0] out_col,
  output logic [gwps_pkg::POS_OUT_W-1:0] out_row
);
  import gwps_pkg::*;

  logic [2*POS_OUT_W-1:0] slot [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign {out_col, out_row} = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {push_col, push_row};
    end
  end

  `GWPS_ASSERT_IMP(no_push_when_full, count == 2'd2, !push, "push into a full queue")
  `GWPS_ASSERT_NXT(fill_count, push && !pop, count == $past(count) + 2'd1,
                   "count missed a push")
  `GWPS_ASSERT_NXT(drain_count, pop && !push, count == $past(count) - 2'd1,
                   "count missed a pop")

endmodule

`default_nettype wire

### sv/greedy_window_point_sampler_unit.sv
// Channel  | Dir | Payload                          | Request taken when
// ---------+-----+----------------------------------+----------------------------
// pixel    | in  | pixel_value, start_of_frame      | pixel.valid && pixel.ready
// center   | out | center_col, center_row           | center.valid && center.ready
// cfg      | in  | cfg_index, cfg_data              | cfg_we (no wait)
//
// One pixel per cycle in steady state; a center shows up in the output queue
// the cycle after its pixel and the queue keeps taking pixels while one waits.
// Per-column state lives in a ring of MAX_WIDTH cells that moves one cell per
// pixel, so a taken pixel finds its column in the head cell; no memory sweep.
// Reset is synchronous; cell marks clear at once, the first cycle after reset
// sets the ring length, then pixels flow.
// A width change re-aligns the ring before the next pixel is taken, with
// pixel.ready low: rotate to phase 0, set the length, rotate to the column.
// A full two-entry output queue also drops pixel.ready.

`default_nettype none

`include "greedy_window_point_sampler_unit_assert.svh"

module greedy_window_point_sampler_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  gwps_pix_if.sink                       pixel,
  gwps_ctr_if.source                     center,
  input  logic                           cfg_we,
  input  logic [gwps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwps_pkg::CFG_W-1:0]     cfg_data
);
  import gwps_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int LW = $clog2(MAX_WIDTH + 1);   // width / ring length 1..MAX_WIDTH
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // height 1..MAX_HEIGHT
  localparam int AW = ((LW > RADIUS_W) ? LW : RADIUS_W) + 1;
  localparam int EW = ((RW > RADIUS_W) ? RW : RADIUS_W) + 1;

  // ---------------------------------------------------------------- config
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [KERNEL_W-1:0]     kernel_size;
  logic [PIX_W-1:0]        foreground_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RST;
      image_height     <= HEIGHT_RST;
      kernel_size      <= KERNEL_RST;
      foreground_value <= FG_RST;
    end else if (cfg_we) begin
      unique case (gwps_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width      <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height     <= cfg_data[HEIGHT_REG_W-1:0];
        REG_KERNEL_SIZE:  kernel_size      <= cfg_data[KERNEL_W-1:0];
        REG_FOREGROUND:   foreground_value <= cfg_data[PIX_W-1:0];
      endcase
    end
  end

  // zero reads as one, large values saturate at the build limits
  logic [LW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;
  logic [RADIUS_W-1:0] radius;

  always_comb begin
    if (image_width == '0) begin
      w_eff = LW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // even kernel rounds up to odd, so radius is kernel/2, capped at RADIUS_MAX
  assign radius = (kernel_size[KERNEL_W-1:1] > RADIUS_MAX) ? RADIUS_MAX
                                                           : kernel_size[KERNEL_W-1:1];

  // ------------------------------------------------------ position and ring
  // Ring invariant: cell k holds column (ring_phase + k) mod ring_len for
  // k < ring_len, and column k for the parked cells above. A pixel may only
  // be taken when the head cell holds its column under the current width.
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [LW-1:0] ring_len;
  logic [CW-1:0] ring_phase;

  logic [LW-1:0] len_req;
  logic          aligned;
  logic          relen;
  logic          rotate;
  logic          q_space;
  logic          fire;
  logic          sof;

  // a column left beyond a shrunken width gets a ring just long enough for it
  assign len_req = (LW'(col) < w_eff) ? w_eff : (LW'(col) + LW'(1));
  assign aligned = (ring_len == len_req) && (ring_phase == col);
  // length may only change while cell k holds column k
  assign relen   = !aligned && (ring_len != len_req) && (ring_phase == '0);
  assign rotate  = !aligned && !relen;

  assign pixel.ready = aligned && q_space;
  assign fire        = pixel.valid && pixel.ready;
  assign sof         = pixel.start_of_frame;

  // position of the pixel at the input, after a possible frame start
  logic [CW-1:0] colc;
  logic [RW-1:0] rowc;
  logic [LW-1:0] shift_len;
  logic [CW-1:0] phase_base;
  logic [CW-1:0] phase_next;

  assign colc       = sof ? '0 : col;
  assign rowc       = sof ? '0 : row;
  assign shift_len  = (fire && sof) ? w_eff : ring_len;
  assign phase_base = (fire && sof) ? '0 : ring_phase;
  assign phase_next = ((LW'(phase_base) + LW'(1)) == shift_len) ? '0
                                                                : (phase_base + CW'(1));

  // ------------------------------------------------------ window in ring terms
  logic          in_range;
  logic [AW-1:0] rad_a;
  logic [AW-1:0] col_a;
  logic [AW-1:0] room_a;
  logic [AW-1:0] back_a;
  logic [LW-1:0] ahead_hi;
  logic [LW-1:0] behind_lo;
  logic [LW-1:0] behind_hi;
  logic [EW-1:0] end_sum;
  logic [EW-1:0] end_max;
  logic [RW-1:0] wr_end;

  assign in_range  = LW'(colc) < w_eff;
  assign rad_a     = AW'(radius);
  assign col_a     = AW'(colc);
  // columns to the right edge, and to the left edge up to the radius
  assign room_a    = AW'(w_eff) - col_a - AW'(1);
  assign back_a    = (rad_a < col_a) ? rad_a : col_a;
  assign ahead_hi  = LW'((rad_a < room_a) ? rad_a : room_a);
  assign behind_lo = LW'(AW'(shift_len) - back_a);
  // beyond a shrunken width only columns up to width-1 are written
  assign behind_hi = in_range ? (shift_len - LW'(1)) : w_eff;

  assign end_sum = EW'(rowc) + EW'(radius);
  assign end_max = EW'(h_eff) - EW'(1);
  assign wr_end  = RW'((end_sum > end_max) ? end_max : end_sum);

  // ------------------------------------------------------------ head lookup
  logic          head_valid;
  logic [RW-1:0] head_end;
  logic          suppressed;
  logic          hit;

  assign suppressed = !sof && head_valid && (rowc <= head_end);
  assign hit        = fire && (pixel.pixel_value == foreground_value) && !suppressed;

  // ------------------------------------------------------------ next position
  logic [LW-1:0] col1;
  logic [HW-1:0] row1;
  logic          wrap_col;
  logic          overrun;

  assign col1     = LW'(colc) + LW'(1);
  assign row1     = HW'(rowc) + HW'(1);
  assign wrap_col = col1 >= w_eff;
  assign overrun  = row1 >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      ring_len   <= LW'(1);
      ring_phase <= '0;
    end else if (fire) begin
      ring_len   <= shift_len;
      ring_phase <= phase_next;
      if (wrap_col) begin
        col <= '0;
        row <= overrun ? '0 : RW'(row1);
      end else begin
        col <= CW'(col1);
        row <= rowc;
      end
    end else if (rotate) begin
      ring_phase <= phase_next;
    end else if (relen) begin
      ring_len <= len_req;
    end
  end

  // ------------------------------------------------------------ cell ring
  gwps_ctl_t ctl;

  assign ctl.shift     = fire || rotate;
  assign ctl.sof_clear = fire && sof;
  assign ctl.clear_all = fire && wrap_col && overrun;
  assign ctl.wr_en     = hit;
  assign ctl.ahead_en  = in_range;

  logic          post_v [MAX_WIDTH];
  logic [RW-1:0] post_e [MAX_WIDTH];
  logic          cur_v  [MAX_WIDTH];
  logic [RW-1:0] cur_e  [MAX_WIDTH];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    localparam int RIGHT = (k == MAX_WIDTH - 1) ? 0 : k + 1;
    gwps_cell #(
      .IDX (k),
      .LW  (LW),
      .RW  (RW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .len         (shift_len),
      .ahead_hi    (ahead_hi),
      .behind_lo   (behind_lo),
      .behind_hi   (behind_hi),
      .wr_end      (wr_end),
      .right_valid (post_v[RIGHT]),
      .right_end   (post_e[RIGHT]),
      .wrap_valid  (post_v[0]),
      .wrap_end    (post_e[0]),
      .cur_valid   (cur_v[k]),
      .cur_end     (cur_e[k]),
      .post_valid  (post_v[k]),
      .post_end    (post_e[k])
    );
  end

  assign head_valid = cur_v[0];
  assign head_end   = cur_e[0];

  // ------------------------------------------------------------ output queue
  gwps_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (hit),
    .push_col  (POS_OUT_W'(colc)),
    .push_row  (POS_OUT_W'(rowc)),
    .space     (q_space),
    .out_valid (center.valid),
    .out_ready (center.ready),
    .out_col   (center.center_col),
    .out_row   (center.center_row)
  );

  `GWPS_ASSERT_IMP(phase_in_ring, 1'b1, LW'(ring_phase) < ring_len,
                   "ring phase beyond ring length")
  `GWPS_ASSERT_NXT(overrun_clears_head, ctl.clear_all, !head_valid,
                   "head cell still marked after frame overrun")
  `GWPS_ASSERT_NXT(center_is_queued, hit, center.valid,
                   "new center did not reach the output queue")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gwps_pkg::*;

  // Largest frame the block is built for (instance uses the default parameters).
  localparam int FRAME_MAX = 1024;
  // Random phases repeat until this many pixel requests have gone in.
  localparam int unsigned PIXEL_TARGET = 1150;

  typedef struct packed {
    logic [POS_OUT_W-1:0] col;
    logic [POS_OUT_W-1:0] row;
  } center_t;

  // Tracks the sampler: its registers, the per-column suppression store and the
  // raster position. Every accepted pixel request may queue one expected center.
  class center_predictor;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [KERNEL_W-1:0] kernel_reg;
    logic [PIX_W-1:0]    fg_reg;
    logic [CFG_W-1:0]    supp_end [FRAME_MAX];
    bit                  supp_valid [FRAME_MAX];
    int unsigned         row_pos;
    int unsigned         col_pos;
    center_t             centers_due [$];
    int                  errors;

    function void clear_frame();
      foreach (supp_valid[i]) begin
        supp_valid[i] = 1'b0;
        supp_end[i]   = '0;
      end
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void power_on();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      kernel_reg = KERNEL_RST;
      fg_reg     = FG_RST;
      errors     = 0;
      centers_due.delete();
      clear_frame();
    endfunction

    function void write_reg(gwps_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = v;
        REG_IMAGE_HEIGHT: height_reg = v;
        REG_KERNEL_SIZE:  kernel_reg = v[KERNEL_W-1:0];
        REG_FOREGROUND:   fg_reg     = v[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    // zero reads as one, anything past the build limit saturates
    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      return (v > FRAME_MAX) ? FRAME_MAX : v;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pv, logic sof);
      int unsigned w, h, k, rad, lo, hi, last_row, col, row;
      center_t     c_new;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (sof) clear_frame();
      col = col_pos;
      row = row_pos;
      if (col < FRAME_MAX && pv == fg_reg) begin
        if (!(supp_valid[col] && row <= supp_end[col])) begin
          // even sizes go up by one, then cap at the largest odd legal side
          k = kernel_reg | 1;
          if (k > ((MAX_KERNEL - 1) | 1)) k = (MAX_KERNEL - 1) | 1;
          rad = k / 2;
          lo = (col > rad) ? col - rad : 0;
          hi = col + rad;
          last_row = row + rad;
          if (hi > w - 1) hi = w - 1;
          if (last_row > h - 1) last_row = h - 1;
          for (int unsigned c = lo; c <= hi && c < FRAME_MAX; c++) begin
            supp_end[c]   = CFG_W'(last_row);
            supp_valid[c] = 1'b1;
          end
          c_new.col = col[POS_OUT_W-1:0];
          c_new.row = row[POS_OUT_W-1:0];
          centers_due = {centers_due, c_new};
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        // ran off the bottom: behaves like a fresh frame
        if (row >= h) begin
          clear_frame();
          return;
        end
      end
      col_pos = col;
      row_pos = row;
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_center(logic [POS_OUT_W-1:0] c, logic [POS_OUT_W-1:0] r);
      center_t e;
      if (centers_due.size() == 0) begin
        report($sformatf("center col %0d row %0d with none expected", c, r));
        return;
      end
      e = centers_due.pop_front();
      if (c !== e.col) report($sformatf("center_col %0d, expected %0d", c, e.col));
      if (r !== e.row) report($sformatf("center_row %0d, expected %0d", r, e.row));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gwps_pix_if pix_ch ();
  gwps_ctr_if ctr_ch ();

  greedy_window_point_sampler_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_ch),
    .center    (ctr_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  center_predictor sb;

  // Phase-wide switches for back-to-back stretches on either side.
  bit          tx_steady;
  bit          rx_steady;
  int unsigned pixels_sent;

  // Corner values for the dimension registers (zero and past-limit included).
  logic [CFG_W-1:0]    dim_picks [6] = '{11'd0, 11'd1, 11'd2, 11'd1023, 11'd1024, 11'd2047};
  logic [KERNEL_W-1:0] kern_picks [5] = '{6'd0, 6'd1, 6'd2, 6'd62, 6'd63};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both monitors sample at the edge, before any register update lands.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready)
      sb.note_pixel(pix_ch.pixel_value, pix_ch.start_of_frame);
    if (!rst && ctr_ch.valid && ctr_ch.ready)
      sb.check_center(ctr_ch.center_col, ctr_ch.center_row);
  end

  // Center sink: random stall before each request, none in steady phases.
  initial begin
    int stall;
    ctr_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        ctr_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ctr_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(ctr_ch.valid && ctr_ch.ready)) @(posedge clk);
    end
  end

  // One pixel request; valid stays up when the next gap is zero.
  task automatic send_pixel(logic [PIX_W-1:0] pv, logic sof);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.pixel_value    <= pv;
    pix_ch.start_of_frame <= sof;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Hold off the source until every expected center is out.
  task automatic pause_until_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.centers_due.size() != 0) @(posedge clk);
  endtask

  // Drained plus slack: a pixel that makes no center may still be in flight.
  task automatic go_idle();
    pause_until_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(gwps_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic program_regs(bit [3:0] mask, logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv,
                              logic [KERNEL_W-1:0] kv, logic [PIX_W-1:0] fv);
    if (mask[0]) write_reg(REG_IMAGE_WIDTH, wv);
    if (mask[1]) write_reg(REG_IMAGE_HEIGHT, hv);
    if (mask[2]) write_reg(REG_KERNEL_SIZE, CFG_W'(kv));
    if (mask[3]) write_reg(REG_FOREGROUND, CFG_W'(fv));
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0]    wv, hv;
    logic [KERNEL_W-1:0] kv;
    logic [PIX_W-1:0]    fv, pv;
    logic                sof;
    int                  n, sel;
    go_idle();
    if ($urandom_range(0, 7) == 0) begin
      // corner settings: huge or degenerate frames, extreme kernels
      wv = dim_picks[$urandom_range(0, 5)];
      hv = dim_picks[$urandom_range(0, 5)];
      kv = kern_picks[$urandom_range(0, 4)];
    end else begin
      // mostly small frames so rows wrap and frames overrun often
      wv = CFG_W'($urandom_range(1, 40));
      hv = CFG_W'($urandom_range(1, 24));
      kv = ($urandom_range(0, 3) == 0) ? KERNEL_W'($urandom_range(0, 63))
                                       : KERNEL_W'($urandom_range(0, 9));
    end
    sel = $urandom_range(0, 3);
    fv = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : PIX_W'($urandom_range(0, 255));
    program_regs(4'($urandom_range(1, 15)), wv, hv, kv, fv);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    n = $urandom_range(20, 120);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 4);
      if (sel < 2)
        pv = sb.fg_reg;
      else if (sel == 2)
        pv = sb.fg_reg ^ (8'd1 << $urandom_range(0, 7));  // near miss
      else
        pv = PIX_W'($urandom_range(0, 255));
      // most phases open a frame; the rest carry on the old one, maybe resized
      sof = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 79) == 0);
      if ($urandom_range(0, 149) == 0) pause_until_drained();
      send_pixel(pv, sof);
    end
  endtask

  initial begin
    sb = new;
    sb.power_on();
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    pixels_sent = 0;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_IMAGE_WIDTH;
    cfg_data              <= '0;
    pix_ch.valid          <= 1'b0;
    pix_ch.pixel_value    <= '0;
    pix_ch.start_of_frame <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Reset settings (1024x1024, side 15, foreground 255): first pixel is a
    // center, its neighbor is suppressed, non-foreground values pass.
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd254, 1'b0);

    // 3x2 frame, even side rounds up to 3, foreground 0: window clipped at the
    // right and bottom, then an overrun wraps into a fresh frame with no flag.
    go_idle();
    program_regs(4'b1111, 11'd3, 11'd2, 6'd2, 8'd0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);

    // Zero width and height act as 1x1; zero side acts as 1: every foreground
    // pixel is a center at the origin.
    go_idle();
    program_regs(4'b0111, 11'd0, 11'd0, 6'd0, 8'd0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd0, 1'b1);

    // Oversized width and height saturate, widest kernel.
    go_idle();
    program_regs(4'b1111, 11'd2047, 11'd2047, 6'd63, 8'd128);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd128, 1'b0);

    while (pixels_sent < PIXEL_TARGET) random_phase();

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (sb.centers_due.size() != 0)
      sb.report($sformatf("%0d expected centers never came out", sb.centers_due.size()));
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
